### design/assert_macros.svh
// Assertion macros for the design file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define CHECK_ON(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/bffa_pkg.sv
// Field widths, codes and controller/datapath link types of the bitmap allocator.
package bffa_pkg;

   localparam int FUNC_W = 2;
   localparam int IDX_W  = 12;
   localparam int RUN_W  = 6;
   localparam int CNT_W  = 13;
   localparam int STAT_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [STAT_W-1:0] ST_REDUNDANT = 2'd3;

   localparam logic [CNT_W-1:0] LIMIT_RESET = 13'd4096;

   typedef struct packed {
      logic start;
      logic count_step;
      logic seek_read;
      logic advance;
      logic alloc_start;
      logic load;
      logic grant;
      logic single;
      logic nospace;
   } cmd_type;

   typedef struct packed {
      logic alloc_ok;
      logic last_word;
      logic past_lim;
      logic cur_free;
      logic pick_found;
      logic last_grant;
   } stat_type;

endpackage

### design/bffa_channels.sv
// Handshake channel interfaces: request, response and register write.
interface bffa_req_if;
   logic                        valid;
   logic                        ready;
   logic [bffa_pkg::FUNC_W-1:0] func;
   logic [bffa_pkg::IDX_W-1:0]  entry_index;
   logic [bffa_pkg::RUN_W-1:0]  request_count;

   modport source (output valid, output func, output entry_index, output request_count,
                   input ready);
   modport sink   (input valid, input func, input entry_index, input request_count,
                   output ready);
endinterface

interface bffa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bffa_pkg::IDX_W-1:0]  granted_index;
   logic [bffa_pkg::STAT_W-1:0] status;
   logic [bffa_pkg::CNT_W-1:0]  busy_count;
   logic                        last_result;

   modport source (output valid, output granted_index, output status, output busy_count,
                   output last_result, input ready);
   modport sink   (input valid, input granted_index, input status, input busy_count,
                   input last_result, output ready);
endinterface

interface bffa_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bffa_pkg::CNT_W-1:0] entries_in_use;

   modport source (output valid, output entries_in_use, input ready);
   modport sink   (input valid, input entries_in_use, output ready);
endinterface

### design/bffa_ctrl.sv
// Sequencer of the allocator: count pass, word seek, grant run and result hand-off.
module bffa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  bffa_pkg::stat_type stat,
   output bffa_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_COUNT  = 7'b0000010,
      S_DRAIN  = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_SEEK   = 7'b0010000,
      S_LOAD   = 7'b0100000,
      S_GRANT  = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.count_step = 1'b1;
            if (stat.last_word) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.alloc_ok) begin
               cmd.alloc_start = 1'b1;
               state_in        = S_SEEK;
            end else if (slot_free) begin
               cmd.single = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SEEK: begin
            if (stat.past_lim) begin
               if (slot_free) begin
                  cmd.nospace = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (stat.cur_free) begin
               cmd.seek_read = 1'b1;
               state_in      = S_LOAD;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_GRANT;
         end
         S_GRANT: begin
            // word exhausted below the limit: move on to the next word
            if (!stat.pick_found) begin
               cmd.advance = 1'b1;
               state_in    = S_SEEK;
            end else if (slot_free) begin
               cmd.grant = 1'b1;
               if (stat.last_grant) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.single || cmd.nospace || cmd.grant) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/bffa_dpath.sv
// Free map memory, busy counter, word scan pointer and grant/update logic.
module bffa_dpath #(
   parameter int MAP_ENTRIES = 4096,
   parameter int WORD_BITS   = 32,
   parameter int MAX_RUN     = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bffa_pkg::cmd_type             cmd,
   output bffa_pkg::stat_type            stat,
   input  logic [bffa_pkg::CNT_W-1:0]    limit_cfg,
   input  logic [bffa_pkg::FUNC_W-1:0]   req_func,
   input  logic [bffa_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [bffa_pkg::RUN_W-1:0]    req_request_count,
   output logic [bffa_pkg::IDX_W-1:0]    out_index,
   output logic [bffa_pkg::STAT_W-1:0]   out_status,
   output logic [bffa_pkg::CNT_W-1:0]    out_busy,
   output logic                          out_last
);

   localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int EW        = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
   localparam int OW        = $clog2(WORD_BITS);
   localparam int CW        = $clog2(MAP_ENTRIES + 1);

   // map storage; a word never written reads as all free
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] word_valid_ff;
   logic [MAP_WORDS-1:0] word_free_ff;

   logic [bffa_pkg::FUNC_W-1:0] func_ff;
   logic [bffa_pkg::IDX_W-1:0]  idx_ff;
   logic [bffa_pkg::RUN_W-1:0]  want_ff;
   logic [EW-1:0]               lim_ff, lim_in;
   logic [AW-1:0]               ptr_ff;
   logic [EW-1:0]               base_ff;
   logic [WORD_BITS-1:0]        rd_data_ff;
   logic                        rd_fresh_ff;
   logic                        s1_live_ff;
   logic [AW-1:0]               s1_ptr_ff;
   logic [EW-1:0]               s1_base_ff;
   logic [CW-1:0]               busy_ff, busy_in;
   logic [WORD_BITS-1:0]        hit_word_ff;
   logic [AW-1:0]               hit_ptr_ff;
   logic [OW-1:0]               hit_off_ff;
   logic [WORD_BITS-1:0]        work_ff;

   logic [WORD_BITS-1:0]        word_rd;
   logic [CW-1:0]               s1_busy;
   logic                        s1_hit;
   logic [WORD_BITS-1:0]        avail;
   logic [OW-1:0]               pick;
   logic [WORD_BITS-1:0]        work_next;
   logic [bffa_pkg::IDX_W-1:0]  grant_index;
   logic                        in_range;
   logic                        bit_now;
   logic [bffa_pkg::IDX_W-1:0]  sg_index;
   logic [bffa_pkg::STAT_W-1:0] sg_status;
   logic                        sg_write;
   logic                        sg_up;
   logic                        sg_down;
   logic [WORD_BITS-1:0]        sg_data;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [WORD_BITS-1:0]        wr_data;

   // entries of the word at base that lie below the limit
   function automatic logic [WORD_BITS-1:0] live_mask(input logic [EW-1:0] base,
                                                      input logic [EW-1:0] lim);
      logic [EW-1:0]        r;
      logic [WORD_BITS-1:0] m;
      r = lim - base;
      for (int b = 0; b < WORD_BITS; b++) begin
         m[b] = (lim > base) && (32'(r) > 32'(b));
      end
      return m;
   endfunction

   always_comb begin
      if (32'(limit_cfg) > 32'(MAP_ENTRIES)) begin
         lim_in = EW'(MAP_ENTRIES);
      end else begin
         lim_in = EW'(limit_cfg);
      end
   end

   assign word_rd = rd_fresh_ff ? rd_data_ff : '1;
   assign s1_busy = CW'($countones(~word_rd & live_mask(s1_base_ff, lim_ff)));
   assign s1_hit  = (32'(idx_ff) >= 32'(s1_base_ff)) &&
                    (32'(idx_ff) < 32'(s1_base_ff) + 32'(WORD_BITS));

   assign avail = work_ff & live_mask(base_ff, lim_ff);

   // lowest free entry of the working word
   always_comb begin
      pick = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) pick = OW'(b);
      end
   end

   assign work_next   = work_ff & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << pick);
   assign grant_index = bffa_pkg::IDX_W'(32'(base_ff) + 32'(pick));
   assign in_range    = 32'(idx_ff) < 32'(lim_ff);
   assign bit_now     = hit_word_ff[hit_off_ff];

   // single-result requests: bad count, unknown code, release, reserve
   always_comb begin
      sg_index  = idx_ff;
      sg_status = bffa_pkg::ST_RANGE;
      sg_write  = 1'b0;
      sg_up     = 1'b0;
      sg_down   = 1'b0;
      sg_data   = hit_word_ff;
      if (func_ff == bffa_pkg::FUNC_ALLOC) begin
         sg_index = '0;
      end else if (in_range && func_ff == bffa_pkg::FUNC_RELEASE) begin
         if (bit_now) begin
            sg_status = bffa_pkg::ST_REDUNDANT;
         end else begin
            sg_status = bffa_pkg::ST_OK;
            sg_write  = 1'b1;
            sg_down   = 1'b1;
            sg_data   = hit_word_ff | ({{(WORD_BITS-1){1'b0}}, 1'b1} << hit_off_ff);
         end
      end else if (in_range && func_ff == bffa_pkg::FUNC_RESERVE) begin
         if (!bit_now) begin
            sg_status = bffa_pkg::ST_REDUNDANT;
         end else begin
            sg_status = bffa_pkg::ST_OK;
            sg_write  = 1'b1;
            sg_up     = 1'b1;
            sg_data   = hit_word_ff & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << hit_off_ff);
         end
      end
   end

   always_comb begin
      if (cmd.grant || (cmd.single && sg_up)) begin
         busy_in = busy_ff + CW'(1);
      end else if (cmd.single && sg_down) begin
         busy_in = busy_ff - CW'(1);
      end else begin
         busy_in = busy_ff;
      end
   end

   always_comb begin
      wr_en   = cmd.grant || (cmd.single && sg_write);
      wr_addr = cmd.grant ? ptr_ff : hit_ptr_ff;
      wr_data = cmd.grant ? work_next : sg_data;
   end

   always_comb begin
      stat.alloc_ok   = (func_ff == bffa_pkg::FUNC_ALLOC) && (want_ff != '0) &&
                        (32'(want_ff) <= 32'(MAX_RUN));
      stat.last_word  = ptr_ff == AW'(MAP_WORDS - 1);
      stat.past_lim   = base_ff >= lim_ff;
      stat.cur_free   = !word_valid_ff[ptr_ff] || word_free_ff[ptr_ff];
      stat.pick_found = |avail;
      stat.last_grant = want_ff == bffa_pkg::RUN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      if (cmd.count_step || cmd.seek_read) begin
         rd_data_ff  <= map_mem[ptr_ff];
         rd_fresh_ff <= word_valid_ff[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         word_free_ff  <= '1;
         s1_live_ff    <= 1'b0;
      end else begin
         s1_live_ff <= cmd.count_step;
         if (wr_en) begin
            word_valid_ff[wr_addr] <= 1'b1;
            word_free_ff[wr_addr]  <= |wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff <= req_func;
         idx_ff  <= req_entry_index;
         lim_ff  <= lim_in;
      end
      if (cmd.start) begin
         want_ff <= req_request_count;
      end else if (cmd.grant) begin
         want_ff <= want_ff - bffa_pkg::RUN_W'(1);
      end
      if (cmd.start || cmd.alloc_start) begin
         ptr_ff  <= '0;
         base_ff <= '0;
      end else if (cmd.count_step || cmd.advance) begin
         ptr_ff  <= ptr_ff + AW'(1);
         base_ff <= base_ff + EW'(WORD_BITS);
      end
      s1_ptr_ff  <= ptr_ff;
      s1_base_ff <= base_ff;
      // accumulate the busy entries of each word as it leaves the read register
      if (cmd.start) begin
         busy_ff <= '0;
      end else if (s1_live_ff) begin
         busy_ff <= busy_ff + s1_busy;
      end else begin
         busy_ff <= busy_in;
      end
      if (s1_live_ff && s1_hit) begin
         hit_word_ff <= word_rd;
         hit_ptr_ff  <= s1_ptr_ff;
         hit_off_ff  <= OW'(32'(idx_ff) - 32'(s1_base_ff));
      end
      if (cmd.load) begin
         work_ff <= word_rd;
      end else if (cmd.grant) begin
         work_ff <= work_next;
      end
      if (cmd.grant) begin
         out_index  <= grant_index;
         out_status <= bffa_pkg::ST_OK;
         out_busy   <= bffa_pkg::CNT_W'(busy_in);
         out_last   <= stat.last_grant;
      end else if (cmd.single) begin
         out_index  <= sg_index;
         out_status <= sg_status;
         out_busy   <= bffa_pkg::CNT_W'(busy_in);
         out_last   <= 1'b1;
      end else if (cmd.nospace) begin
         out_index  <= '0;
         out_status <= bffa_pkg::ST_NO_SPACE;
         out_busy   <= bffa_pkg::CNT_W'(busy_ff);
         out_last   <= 1'b1;
      end
   end

endmodule

### design/bitmap_first_fit_allocator.sv
// Top level of the first-fit bitmap allocator: register, sequencer, datapath, checks.
//
//   channel  dir  handshake            payload
//   req_if   in   valid/ready          func, entry_index, request_count
//   rsp_if   out  valid/ready          granted_index, status, busy_count, last_result
//   csr_if   in   valid/ready (ready)  entries_in_use
//
// Every request starts with a busy recount over all map words, one word per cycle
// through the map memory's read port. Release, reserve, unknown codes and bad counts
// end there. An allocate then visits words from the lowest: it skips a full word,
// reads, loads and grants from a word with free entries, seeks on from a word that
// runs dry before the run ends, and gives no-space once past the limit. Reset is
// synchronous; per-word valid bits make the map read as all free at once. A result
// waiting in the response register stalls the next grant, not the scan.
`include "assert_macros.svh"

module bitmap_first_fit_allocator #(
   parameter int MAP_ENTRIES = 4096,
   parameter int WORD_BITS   = 32,
   parameter int MAX_RUN     = 32
) (
   input logic       clock,
   input logic       reset,
   bffa_req_if.sink  req_if,
   bffa_rsp_if.source rsp_if,
   bffa_csr_if.sink  csr_if
);

   logic [bffa_pkg::CNT_W-1:0] limit_ff;
   bffa_pkg::cmd_type          cmd;
   bffa_pkg::stat_type         stat;
   logic                       req_fire;
   logic                       rsp_not_ok;
   logic                       rsp_no_space;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bffa_pkg::LIMIT_RESET;
      end else if (csr_if.valid) begin
         limit_ff <= csr_if.entries_in_use;
      end
   end

   bffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bffa_dpath #(
      .MAP_ENTRIES (MAP_ENTRIES),
      .WORD_BITS   (WORD_BITS),
      .MAX_RUN     (MAX_RUN)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .limit_cfg         (limit_ff),
      .req_func          (req_if.func),
      .req_entry_index   (req_if.entry_index),
      .req_request_count (req_if.request_count),
      .out_index         (rsp_if.granted_index),
      .out_status        (rsp_if.status),
      .out_busy          (rsp_if.busy_count),
      .out_last          (rsp_if.last_result)
   );

   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_not_ok   = rsp_if.valid && (rsp_if.status != bffa_pkg::ST_OK);
   assign rsp_no_space = rsp_if.valid && (rsp_if.status == bffa_pkg::ST_NO_SPACE);

   // one request at a time: the recount pass follows every accept
   `CHECK_ON(a_one_at_a_time, req_fire |=> !req_if.ready, "request accepted during work")
   // only grants can continue a run; every other result ends the request
   `CHECK_ON(a_fail_is_last, rsp_not_ok |-> rsp_if.last_result, "non-ok result not last")
   `CHECK_ON(a_nospace_zero, rsp_no_space |-> (rsp_if.granted_index == '0), "no-space with index")
   `CHECK_ALWAYS(a_reset_quiet, reset |=> !rsp_if.valid, "response valid after reset")

endmodule

### tb/sv/tb_rsp_checker.sv
`timescale 1ns / 1ps
// Response checker: mirrors the free map from observed requests and compares each response.
module tb_rsp_checker
   import bffa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bffa_req_if  req_mon,
   bffa_rsp_if  rsp_mon,
   bffa_csr_if  csr_mon,
   output int   mismatches,
   output int   outstanding
);

   localparam int MAP_ENTRIES = 4096;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = MAP_ENTRIES / WORD_BITS;
   localparam int MAX_RUN     = 32;
   localparam int PRINT_CAP   = 60;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [STAT_W-1:0] status;
      logic [CNT_W-1:0]  busy;
      logic              last;
   } rsp_item_t;

   logic [WORD_BITS-1:0] free_words [MAP_WORDS];
   logic [CNT_W-1:0]     volume_limit;
   logic [CNT_W-1:0]     busy_now;
   rsp_item_t            awaited_rsp [$];

   task automatic report(string msg);
      if (mismatches < PRINT_CAP) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   function automatic logic entry_free(int e);
      return free_words[e / WORD_BITS][e % WORD_BITS];
   endfunction

   function automatic void mark_entry(int e, logic is_free);
      free_words[e / WORD_BITS][e % WORD_BITS] = is_free;
   endfunction

   function automatic void push_rsp(int idx, logic [STAT_W-1:0] st, logic last);
      rsp_item_t r;
      r.index  = idx[IDX_W-1:0];
      r.status = st;
      r.busy   = busy_now;
      r.last   = last;
      awaited_rsp.push_back(r);
   endfunction

   // Compute every response one request causes and update the mirrored map.
   function automatic void apply_request(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                                         logic [RUN_W-1:0] cnt);
      int lim;
      int words;
      int w;
      int e;
      int left;
      lim = (volume_limit > MAP_ENTRIES) ? MAP_ENTRIES : int'(volume_limit);
      busy_now = '0;
      for (e = 0; e < lim; e++) begin
         if (!entry_free(e)) busy_now++;
      end
      if (func == FUNC_ALLOC) begin
         if (cnt == 0 || cnt > MAX_RUN) begin
            push_rsp(0, ST_RANGE, 1'b1);
            return;
         end
         words = (lim + WORD_BITS - 1) / WORD_BITS;
         w = 0;
         // skip words with no free entry at all
         while (w < words && free_words[w] == '0) w++;
         e = w * WORD_BITS;
         left = int'(cnt);
         while (left > 0 && e < lim) begin
            if (entry_free(e)) begin
               mark_entry(e, 1'b0);
               busy_now++;
               left--;
               push_rsp(e, ST_OK, left == 0);
            end
            e++;
         end
         if (left > 0) push_rsp(0, ST_NO_SPACE, 1'b1);
      end else if ((func != FUNC_RELEASE && func != FUNC_RESERVE) || int'(idx) >= lim) begin
         push_rsp(int'(idx), ST_RANGE, 1'b1);
      end else if (func == FUNC_RELEASE) begin
         if (entry_free(int'(idx))) begin
            push_rsp(int'(idx), ST_REDUNDANT, 1'b1);
         end else begin
            mark_entry(int'(idx), 1'b1);
            busy_now--;
            push_rsp(int'(idx), ST_OK, 1'b1);
         end
      end else begin
         if (!entry_free(int'(idx))) begin
            push_rsp(int'(idx), ST_REDUNDANT, 1'b1);
         end else begin
            mark_entry(int'(idx), 1'b0);
            busy_now++;
            push_rsp(int'(idx), ST_OK, 1'b1);
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_t want;
      if (reset) begin
         foreach (free_words[w]) free_words[w] = '1;
         volume_limit = LIMIT_RESET;
         awaited_rsp.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) volume_limit = csr_mon.entries_in_use;
         // pop before push: a response at this edge belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_rsp.size() == 0) begin
               report($sformatf("unexpected response index %0d status %0d",
                                rsp_mon.granted_index, rsp_mon.status));
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_mon.granted_index !== want.index)
                  report($sformatf("granted_index got %0d expected %0d",
                                   rsp_mon.granted_index, want.index));
               if (rsp_mon.status !== want.status)
                  report($sformatf("status got %0d expected %0d", rsp_mon.status, want.status));
               if (rsp_mon.busy_count !== want.busy)
                  report($sformatf("busy_count got %0d expected %0d",
                                   rsp_mon.busy_count, want.busy));
               if (rsp_mon.last_result !== want.last)
                  report($sformatf("last_result got %0d expected %0d",
                                   rsp_mon.last_result, want.last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.func, req_mon.entry_index, req_mon.request_count);
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, request and register stimulus, response stalls and verdict.
module tb_top;

   localparam logic [bffa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int MAP_ENTRIES   = 4096;

   logic clock;
   logic reset;
   logic steady;
   int   mismatches;
   int   outstanding;
   int   cycles;

   bffa_req_if req_if ();
   bffa_rsp_if rsp_if ();
   bffa_csr_if csr_if ();

   bitmap_first_fit_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   tb_rsp_checker rsp_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Response side: stall at random, except during the steady stretch.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 35);
      end
   end

   // Hold valid across a gap-free sequence; lower it only inside an idle gap.
   task automatic send_request(logic [bffa_pkg::FUNC_W-1:0] f,
                               logic [bffa_pkg::IDX_W-1:0] idx,
                               logic [bffa_pkg::RUN_W-1:0] cnt);
      while (!steady && $urandom_range(0, 99) < 35) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.func          <= f;
      req_if.entry_index   <= idx;
      req_if.request_count <= cnt;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic reconfigure(logic [bffa_pkg::CNT_W-1:0] value);
      drain();
      csr_if.valid          <= 1'b1;
      csr_if.entries_in_use <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic random_request(int lim, int alloc_pct, bit fill);
      int                          pick;
      logic [bffa_pkg::FUNC_W-1:0] f;
      logic [bffa_pkg::IDX_W-1:0]  idx;
      logic [bffa_pkg::RUN_W-1:0]  cnt;
      pick = $urandom_range(0, 99);
      idx  = bffa_pkg::IDX_W'($urandom_range(0, MAP_ENTRIES - 1));
      cnt  = bffa_pkg::RUN_W'($urandom_range(0, 63));
      if (pick < alloc_pct) begin
         f = bffa_pkg::FUNC_ALLOC;
         // mostly legal counts, the rest is noise
         if ($urandom_range(0, 9) != 0) begin
            cnt = fill ? 6'd32 : bffa_pkg::RUN_W'($urandom_range(1, 32));
         end
      end else begin
         f = (pick % 2 == 0) ? bffa_pkg::FUNC_RELEASE : bffa_pkg::FUNC_RESERVE;
         if (pick >= 97) f = FUNC_UNUSED;
         if (lim > 0 && $urandom_range(0, 4) != 0) begin
            idx = bffa_pkg::IDX_W'($urandom_range(0, lim - 1));
         end
      end
      send_request(f, idx, cnt);
   endtask

   task automatic run_phase(logic [bffa_pkg::CNT_W-1:0] limit_val, int items, int alloc_pct,
                            bit fill, bit calm);
      int lim;
      reconfigure(limit_val);
      lim = (limit_val > MAP_ENTRIES) ? MAP_ENTRIES : int'(limit_val);
      steady <= calm;
      for (int i = 0; i < items; i++) begin
         // now and then hold off until every response is back
         if ($urandom_range(0, 49) == 0) drain();
         random_request(lim, alloc_pct, fill);
      end
      steady <= 1'b0;
   endtask

   initial begin
      steady                <= 1'b0;
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.func           <= bffa_pkg::FUNC_ALLOC;
      req_if.entry_index    <= '0;
      req_if.request_count  <= '0;
      csr_if.valid          <= 1'b0;
      csr_if.entries_in_use <= bffa_pkg::LIMIT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset limit
      send_request(bffa_pkg::FUNC_ALLOC, 12'd4095, 6'd1);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd32);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd0);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd33);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd4095, 6'd63);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd0, 6'd0);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd0, 6'd0);
      send_request(bffa_pkg::FUNC_RESERVE, 12'd4095, 6'd0);
      send_request(bffa_pkg::FUNC_RESERVE, 12'd4095, 6'd0);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd4095, 6'd63);
      send_request(FUNC_UNUSED, 12'd4095, 6'd0);
      send_request(FUNC_UNUSED, 12'd0, 6'd63);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd2);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd17, 6'd0);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd5, 6'd0);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd32);

      // small volume: runs out of space
      reconfigure(13'd40);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd40, 6'd0);
      send_request(bffa_pkg::FUNC_RESERVE, 12'd39, 6'd0);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd32);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd1);

      // no entries at all
      reconfigure(13'd0);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd1);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd0, 6'd0);
      send_request(bffa_pkg::FUNC_RESERVE, 12'd4095, 6'd0);

      // limit above the map acts as the full map
      reconfigure(13'd8191);
      send_request(bffa_pkg::FUNC_ALLOC, 12'd0, 6'd3);
      send_request(bffa_pkg::FUNC_RELEASE, 12'd4095, 6'd0);
      send_request(bffa_pkg::FUNC_RESERVE, 12'd4095, 6'd0);

      // random part
      run_phase(13'd4096, 150, 97, 1'b1, 1'b0);
      run_phase(13'd1, 25, 50, 1'b0, 1'b0);
      run_phase(13'd33, 40, 50, 1'b0, 1'b0);
      run_phase(13'd100, 60, 55, 1'b0, 1'b1);
      run_phase(13'd8191, 60, 50, 1'b0, 1'b0);
      run_phase(13'd64, 40, 50, 1'b0, 1'b0);
      run_phase(13'd0, 15, 50, 1'b0, 1'b0);
      repeat (3) begin
         run_phase(bffa_pkg::CNT_W'($urandom_range(1, MAP_ENTRIES)), 30, 55, 1'b0, 1'b0);
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/bffa_pkg.sv
design/bffa_channels.sv
design/bffa_ctrl.sv
design/bffa_dpath.sv
design/bitmap_first_fit_allocator.sv
tb/sv/tb_rsp_checker.sv
tb/sv/tb_top.sv
